>>> design/bire_pkg.sv
package bire_pkg;

   // Field widths.
   localparam int POS_W    = 40;
   localparam int FRAC_W   = 8;
   localparam int FRAME_W  = 32;
   localparam int BEATS_W  = 24;
   localparam int TEMPO_W  = 32;
   localparam int RATE_W   = 18;
   localparam int KIND_W   = 2;
   localparam int ITEMS_W  = 2;

   // Tempo division: (60 * rate) << 24 divided by the interval.
   localparam int PROD_W   = 24;
   localparam int QSHIFT   = 24;
   localparam int NUM_W    = PROD_W + QSHIFT;
   localparam int DEN_W    = POS_W;
   localparam int DCNT_W   = $clog2(NUM_W);

   // Register port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;

   // Register index, taken from the word address bit.
   localparam logic REG_SAMPLE_RATE = 1'b0;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_MARKER  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             last_in_run;
   } req_data_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [FRAME_W-1:0] marker_position;
      logic [BEATS_W-1:0] beat_count;
      logic [TEMPO_W-1:0] tempo_q16;
      logic               end_of_run;
   } rsp_data_type;

   // Source of the result word loaded into the output register.
   typedef enum logic [1:0] {
      SRC_ERROR,
      SRC_OPEN_MARKER,
      SRC_CLOSE_MARKER,
      SRC_SUMMARY
   } src_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic    capture;
      logic    calc_len;
      logic    first;
      logic    step;
      logic    fail;
      logic    clear;
      logic    set_start;
      logic    div_start;
      logic    load;
      src_type src;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic items_zero;
      logic run_failed;
      logic last;
      logic nonincr;
      logic mismatch;
      logic any_marker;
      logic div_busy;
   } status_type;

endpackage

>>> design/beat_interval_run_encoder_unit.sv
// A word is captured, its interval is worked out and it is then decided; a word that opens a run
// or is skipped gives no result, and an error, a marker or a summary is loaded into the output
// register once it is free. The last word of a run waits for the 48-step bit-serial tempo divider.
// Results wait in one output register while the next word is accepted.
// Reset is synchronous and active high: it clears the run state and sets the sample rate to 44100.
module beat_interval_run_encoder_unit
   import bire_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_data_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [RATE_W-1:0] sample_rate_ff, sample_rate_in;
   logic              reg_hit;
   cmd_type           cmd;
   status_type        status;

   // Register decode on the word address.
   assign reg_hit = (csr_paddr[2] == REG_SAMPLE_RATE);

   always_comb begin
      sample_rate_in = sample_rate_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         sample_rate_in = csr_pwdata[RATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= RATE_RESET;
      end else begin
         sample_rate_ff <= sample_rate_in;
      end
   end

   assign csr_prdata = reg_hit ? CSR_DATA_W'(sample_rate_ff) : '0;
   assign csr_pready = 1'b1;

   bire_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bire_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .sample_rate (sample_rate_ff),
      .status      (status),
      .rsp_data    (rsp_data)
   );

endmodule

>>> design/bire_div.sv
module bire_div
   import bire_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUM_W-1:0]   dividend,
   input  logic [DEN_W-1:0]   divisor,
   output logic               busy,
   output logic [TEMPO_W-1:0] quotient
);

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [DEN_W:0]    rem_shift;
   logic [DEN_W+1:0]  trial;
   logic              fits;

   // One restoring step: shift in the next dividend bit and try to subtract.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[NUM_W-1]};
      trial     = {1'b0, rem_shift} - {2'b00, den_ff};
      fits      = !trial[DEN_W+1];
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = DCNT_W'(NUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   // The quotient saturates to 32 bits.
   assign busy     = busy_ff;
   assign quotient = (|quo_ff[NUM_W-1:TEMPO_W]) ? '1 : quo_ff[TEMPO_W-1:0];

endmodule

>>> design/bire_dp.sv
module bire_dp
   import bire_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  req_data_type      req_data,
   input  logic [RATE_W-1:0] sample_rate,
   output status_type        status,
   output rsp_data_type      rsp_data
);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               last_ff, last_in;
   logic [POS_W-1:0]   len_ff, len_in;
   logic               nonincr_ff, nonincr_in;
   logic [POS_W-1:0]   run_start_ff, run_start_in;
   logic [POS_W-1:0]   prev_ff, prev_in;
   logic [POS_W-1:0]   interval_ff, interval_in;
   logic [BEATS_W-1:0] beats_ff, beats_in;
   logic [ITEMS_W-1:0] items_ff, items_in;
   logic               any_marker_ff, any_marker_in;
   logic               failed_ff, failed_in;
   logic [FRAME_W-1:0] m1_pos_ff, m1_pos_in;
   logic [BEATS_W-1:0] m1_beats_ff, m1_beats_in;
   rsp_data_type       rsp_ff, rsp_in;

   logic [POS_W:0]     len_wide;
   logic               items_one;
   logic [POS_W-1:0]   cmp_interval;
   logic [POS_W-1:0]   diff_up, diff_dn, diff;
   logic               mismatch;
   logic [PROD_W-1:0]  rate_ext;
   logic [PROD_W-1:0]  rate_x60;
   logic [TEMPO_W-1:0] tempo;
   logic               div_busy;

   // Beat interval; a borrow or a zero length marks a non-increasing position.
   assign len_wide = {1'b0, pos_ff} - {1'b0, prev_ff};

   // Compare the new interval with the running one (the first interval matches itself).
   always_comb begin
      items_one    = (items_ff == ITEMS_W'(1));
      cmp_interval = items_one ? len_ff : interval_ff;
      diff_up      = cmp_interval - len_ff;
      diff_dn      = len_ff - cmp_interval;
      diff         = (cmp_interval >= len_ff) ? diff_up : diff_dn;
      mismatch     = |diff[POS_W-1:FRAC_W];
   end

   // Tempo numerator: 60 * rate, built from two shifts.
   always_comb begin
      rate_ext = PROD_W'(sample_rate);
      rate_x60 = (rate_ext << 6) - (rate_ext << 2);
   end

   bire_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({rate_x60, {QSHIFT{1'b0}}}),
      .divisor  (interval_ff),
      .busy     (div_busy),
      .quotient (tempo)
   );

   // Run state update.
   always_comb begin
      pos_in        = pos_ff;
      last_in       = last_ff;
      len_in        = len_ff;
      nonincr_in    = nonincr_ff;
      run_start_in  = run_start_ff;
      prev_in       = prev_ff;
      interval_in   = interval_ff;
      beats_in      = beats_ff;
      items_in      = items_ff;
      any_marker_in = any_marker_ff;
      failed_in     = failed_ff;
      m1_pos_in     = m1_pos_ff;
      m1_beats_in   = m1_beats_ff;

      if (cmd.capture) begin
         pos_in  = req_data.position;
         last_in = req_data.last_in_run;
      end

      if (cmd.calc_len) begin
         len_in     = len_wide[POS_W-1:0];
         nonincr_in = len_wide[POS_W] || (len_wide[POS_W-1:0] == '0);
      end

      if (cmd.first) begin
         run_start_in = pos_ff;
         prev_in      = pos_ff;
         beats_in     = '0;
         items_in     = ITEMS_W'(1);
      end

      if (cmd.step) begin
         m1_pos_in   = run_start_ff[POS_W-1:FRAC_W];
         m1_beats_in = beats_ff;
         items_in    = ITEMS_W'(2);
         prev_in     = pos_ff;
         if (mismatch) begin
            any_marker_in = 1'b1;
            run_start_in  = prev_ff;
            interval_in   = len_ff;
            beats_in      = BEATS_W'(1);
         end else begin
            interval_in = cmp_interval;
            if (beats_ff != '1) begin
               beats_in = beats_ff + 1'b1;
            end
         end
      end

      if (cmd.set_start) begin
         run_start_in = pos_ff;
      end

      if (cmd.fail) begin
         failed_in = 1'b1;
      end

      // The end of a run returns the run state to zero.
      if (cmd.clear) begin
         run_start_in  = '0;
         prev_in       = '0;
         interval_in   = '0;
         beats_in      = '0;
         items_in      = '0;
         any_marker_in = 1'b0;
         failed_in     = 1'b0;
      end
   end

   // Output word selection.
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load) begin
         rsp_in = '0;
         case (cmd.src)
            SRC_ERROR: begin
               rsp_in.kind       = KIND_ERROR;
               rsp_in.end_of_run = last_ff;
            end
            SRC_OPEN_MARKER: begin
               rsp_in.kind            = KIND_MARKER;
               rsp_in.marker_position = m1_pos_ff;
               rsp_in.beat_count      = m1_beats_ff;
            end
            SRC_CLOSE_MARKER: begin
               rsp_in.kind            = KIND_MARKER;
               rsp_in.marker_position = run_start_ff[POS_W-1:FRAC_W];
               rsp_in.beat_count      = beats_ff;
            end
            default: begin
               rsp_in.kind            = KIND_SUMMARY;
               rsp_in.marker_position = run_start_ff[POS_W-1:FRAC_W];
               rsp_in.tempo_q16       = tempo;
               rsp_in.end_of_run      = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_start_ff  <= '0;
         prev_ff       <= '0;
         interval_ff   <= '0;
         beats_ff      <= '0;
         items_ff      <= '0;
         any_marker_ff <= 1'b0;
         failed_ff     <= 1'b0;
      end else begin
         run_start_ff  <= run_start_in;
         prev_ff       <= prev_in;
         interval_ff   <= interval_in;
         beats_ff      <= beats_in;
         items_ff      <= items_in;
         any_marker_ff <= any_marker_in;
         failed_ff     <= failed_in;
      end
      pos_ff      <= pos_in;
      last_ff     <= last_in;
      len_ff      <= len_in;
      nonincr_ff  <= nonincr_in;
      m1_pos_ff   <= m1_pos_in;
      m1_beats_ff <= m1_beats_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      status.items_zero = (items_ff == '0);
      status.run_failed = failed_ff;
      status.last       = last_ff;
      status.nonincr    = nonincr_ff;
      status.mismatch   = mismatch;
      status.any_marker = any_marker_ff;
      status.div_busy   = div_busy;
   end

   assign rsp_data = rsp_ff;

endmodule

>>> design/bire_ctrl.sv
module bire_ctrl
   import bire_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LEN,
      ST_DECIDE,
      ST_EMIT_ERR,
      ST_EMIT_M1,
      ST_POST,
      ST_EMIT_M2,
      ST_DIV_WAIT,
      ST_EMIT_SUM
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // The output register can take a word when empty or being drained.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.src   = SRC_ERROR;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LEN;
            end
         end
         ST_LEN: begin
            cmd.calc_len = 1'b1;
            state_in     = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.run_failed) begin
               // A failed run is skipped until its last word.
               cmd.clear = status.last;
               state_in  = ST_IDLE;
            end else if (status.items_zero) begin
               if (status.last) begin
                  state_in = ST_EMIT_ERR;
               end else begin
                  cmd.first = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else if (status.nonincr) begin
               state_in = ST_EMIT_ERR;
            end else begin
               cmd.step = 1'b1;
               state_in = status.mismatch ? ST_EMIT_M1 : ST_POST;
            end
         end
         ST_EMIT_ERR: begin
            if (slot_free) begin
               cmd.load = 1'b1;
               cmd.src  = SRC_ERROR;
               cmd.clear = status.last;
               cmd.fail  = !status.last;
               state_in  = ST_IDLE;
            end
         end
         ST_EMIT_M1: begin
            if (slot_free) begin
               cmd.load = 1'b1;
               cmd.src  = SRC_OPEN_MARKER;
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            // At the end of a run, start the tempo division right away.
            if (status.last) begin
               cmd.div_start = 1'b1;
               state_in      = status.any_marker ? ST_EMIT_M2 : ST_DIV_WAIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_M2: begin
            if (slot_free) begin
               cmd.load      = 1'b1;
               cmd.src       = SRC_CLOSE_MARKER;
               cmd.set_start = 1'b1;
               state_in      = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_EMIT_SUM;
            end
         end
         ST_EMIT_SUM: begin
            if (slot_free) begin
               cmd.load  = 1'b1;
               cmd.src   = SRC_SUMMARY;
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid: set on a load, dropped when the word is taken.
   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> tb/beat_interval_run_encoder_unit_test.sv
module beat_interval_run_encoder_unit_test import bire_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [POS_W-1:0]      POS_MAX    = '1;
   localparam logic [POS_W-1:0]      ONE_FRAME  = POS_W'(1) << FRAC_W;
   localparam logic [BEATS_W-1:0]    BEATS_MAX  = '1;
   localparam logic [TEMPO_W-1:0]    TEMPO_MAX  = '1;
   localparam logic [CSR_ADDR_W-1:0] RATE_ADDR  = CSR_ADDR_W'({REG_SAMPLE_RATE, 2'b00});
   localparam int IDLE_PERCENT    = 24;
   localparam int SETTLE_CYCLES   = 64;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 3000;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_data_type          req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_data_type          rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   beat_interval_run_encoder_unit dut (.*);

   always #6 clock = ~clock;

   // Predictor state: the open section, the run status and the sample rate.
   logic [POS_W-1:0]   sec_start;
   logic [POS_W-1:0]   last_beat;
   logic [POS_W-1:0]   sec_interval;
   logic [BEATS_W-1:0] sec_beats;
   logic [ITEMS_W-1:0] beats_seen;
   bit                 marker_sent;
   bit                 run_broken;
   logic [RATE_W-1:0]  rate_setting = RATE_RESET;

   rsp_data_type expected_words[$];
   rsp_data_type oldest_word;
   int           failures      = 0;
   int           live_words    = 0;
   int           quiet_cycles  = 0;
   int           hold_requests = 0;
   int           hold_served   = 0;
   int           hold_left     = 0;
   bit           sender_idles  = 1'b1;
   bit           receiver_stalls = 1'b1;

   initial begin
      sec_start    = '0;
      last_beat    = '0;
      sec_interval = '0;
      sec_beats    = '0;
      beats_seen   = '0;
      marker_sent  = 1'b0;
      run_broken   = 1'b0;
   end

   function automatic logic [POS_W-1:0] at_frame(input longint frames);
      return POS_W'(frames) << FRAC_W;
   endfunction

   function automatic longint rand_below(input longint n);
      longint r;
      r = longint'({$urandom(), $urandom()} >> 1);
      return r % n;
   endfunction

   // Tempo in 16.16 beats per minute from an interval in 32.8 frames.
   function automatic logic [TEMPO_W-1:0] tempo_for(input logic [POS_W-1:0] ivl);
      logic [63:0] numer;
      logic [63:0] quot;
      numer = 64'(rate_setting) * 64'd60;
      numer = numer << QSHIFT;
      if (ivl == '0) return TEMPO_MAX;
      quot = numer / 64'(ivl);
      return (quot > 64'(TEMPO_MAX)) ? TEMPO_MAX : quot[TEMPO_W-1:0];
   endfunction

   task automatic push_result(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input logic [BEATS_W-1:0] beats,
                              input logic [TEMPO_W-1:0] tempo, input logic run_end);
      rsp_data_type r;
      r.kind            = kind;
      r.marker_position = pos[POS_W-1:FRAC_W];
      r.beat_count      = beats;
      r.tempo_q16       = tempo;
      r.end_of_run      = run_end;
      expected_words = {expected_words, r};
   endtask

   task automatic clear_run();
      sec_start    = '0;
      last_beat    = '0;
      sec_interval = '0;
      sec_beats    = '0;
      beats_seen   = '0;
      marker_sent  = 1'b0;
      run_broken   = 1'b0;
   endtask

   // Works out the result words that one accepted beat word causes.
   task automatic predict_beat(input req_data_type w);
      logic [POS_W-1:0] step_len;
      logic [POS_W-1:0] diff;
      if (run_broken) begin
         if (w.last_in_run) clear_run();
         return;
      end
      live_words++;

      // First position of a run opens the section.
      if (beats_seen == 0) begin
         sec_start  = w.position;
         last_beat  = w.position;
         sec_beats  = '0;
         beats_seen = ITEMS_W'(1);
         if (w.last_in_run) begin
            push_result(KIND_ERROR, '0, '0, '0, 1'b1);
            clear_run();
         end
         return;
      end

      // A position that does not move forward breaks the run.
      if (w.position <= last_beat) begin
         push_result(KIND_ERROR, '0, '0, '0, w.last_in_run);
         if (w.last_in_run) clear_run();
         else run_broken = 1'b1;
         return;
      end

      step_len = w.position - last_beat;
      if (beats_seen == 1) begin
         sec_interval = step_len;
         beats_seen   = ITEMS_W'(2);
      end
      diff = (sec_interval >= step_len) ? sec_interval - step_len : step_len - sec_interval;

      // Matching interval extends the section; otherwise a marker closes it.
      if (diff < ONE_FRAME) begin
         if (sec_beats != BEATS_MAX) sec_beats++;
      end else begin
         push_result(KIND_MARKER, sec_start, sec_beats, '0, 1'b0);
         marker_sent  = 1'b1;
         sec_start    = last_beat;
         sec_interval = step_len;
         sec_beats    = BEATS_W'(1);
      end
      last_beat = w.position;

      if (w.last_in_run) begin
         if (marker_sent) begin
            push_result(KIND_MARKER, sec_start, sec_beats, '0, 1'b0);
            sec_start = w.position;
         end
         push_result(KIND_SUMMARY, sec_start, '0, tempo_for(sec_interval), 1'b1);
         clear_run();
      end
   endtask

   // Offers one beat word, with random idle cycles ahead of it.
   task automatic send_word(input logic [POS_W-1:0] pos, input logic last);
      req_data_type w;
      w.position    = pos;
      w.last_in_run = last;
      if (sender_idles) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      predict_beat(w);
   endtask

   // Stops offering words and waits until the block has gone quiet.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic read_reg(input logic [CSR_ADDR_W-1:0] addr, output logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_rate_readback();
      logic [CSR_DATA_W-1:0] value;
      read_reg(RATE_ADDR, value);
      if (value[RATE_W-1:0] !== rate_setting) begin
         failures++;
         $display("%0t: sample rate readback: expected %0d, got %0d",
                  $time, rate_setting, value[RATE_W-1:0]);
      end
   endtask

   task automatic set_rate(input logic [CSR_DATA_W-1:0] value);
      drain_results();
      write_reg(RATE_ADDR, value);
      rate_setting = value[RATE_W-1:0];
   endtask

   // One run with random content; a share of runs are broken or a single position.
   task automatic send_random_run();
      int unsigned shape;
      int unsigned len;
      int unsigned bad_at;
      int unsigned idx;
      int unsigned r;
      longint mx, cur, step, span, start, prev, p;
      shape = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(2, 10);
      if ($urandom_range(3) == 0) mx = longint'(1) << $urandom_range(1, 34);
      else mx = longint'(1) << $urandom_range(20, 27);
      cur    = rand_below(mx) + 1;
      span   = longint'(POS_MAX) - longint'(len) * (mx + 256);
      start  = rand_below(span + 1);
      bad_at = (shape < 18) ? $urandom_range(1, len - 1) : len;
      if (shape < 6) len = 1;
      prev = start;
      for (idx = 0; idx < len; idx++) begin
         if (idx == 0) begin
            p = start;
         end else if (idx == bad_at) begin
            p = prev - rand_below(((prev < 4096) ? prev : 4096) + 1);
         end else begin
            r = $urandom_range(99);
            if (r < 15) cur = rand_below(mx) + 1;
            step = cur;
            if (r >= 15 && r < 60) step = cur + longint'($urandom_range(510)) - 255;
            if (step < 1) step = 1;
            p = prev + step;
         end
         send_word(p[POS_W-1:0], idx == len - 1);
         prev = p;
      end
   endtask

   task automatic test_register_access();
      check_rate_readback();
      set_rate(32'd12345);
      check_rate_readback();
   endtask

   task automatic test_single_and_steady_runs();
      set_rate(32'(RATE_RESET));
      // A run of one position is an error.
      send_word(at_frame(4096) + 3, 1'b1);
      // Steady run from position zero: summary only.
      send_word('0, 1'b0);
      send_word(at_frame(22050), 1'b0);
      send_word(at_frame(44100), 1'b1);
   endtask

   task automatic test_interval_changes();
      logic [POS_W-1:0] p;
      // Two tempo changes; the last word gives marker, closing marker and summary.
      send_word(at_frame(1000), 1'b0);
      send_word(at_frame(1500), 1'b0);
      send_word(at_frame(2000), 1'b0);
      send_word(at_frame(2800), 1'b0);
      send_word(at_frame(3600), 1'b0);
      send_word(at_frame(4800), 1'b1);
      // Just under one frame of drift matches; exactly one frame does not.
      p = at_frame(70000);
      send_word(p, 1'b0);
      p = p + 40'd2560000;
      send_word(p, 1'b0);
      p = p + 40'd2560255;
      send_word(p, 1'b0);
      p = p + 40'd2560256;
      send_word(p, 1'b1);
   endtask

   task automatic test_broken_runs();
      // Repeated position mid-run; the rest of the run is dropped.
      send_word(at_frame(5000), 1'b0);
      send_word(at_frame(5100), 1'b0);
      send_word(at_frame(5100), 1'b0);
      send_word(at_frame(10), 1'b1);
      // Backward step on the last word.
      send_word(at_frame(100), 1'b0);
      send_word(at_frame(200), 1'b0);
      send_word(at_frame(150), 1'b1);
   endtask

   task automatic test_rate_extremes();
      // Zero rate gives a zero tempo.
      set_rate(32'd0);
      send_word(at_frame(10), 1'b0);
      send_word(at_frame(20), 1'b1);
      // Largest rate and a tiny interval at the top of the range saturate the tempo.
      set_rate(32'hFFFF_FFFF);
      check_rate_readback();
      send_word(40'hFF_FFFF_FF00, 1'b0);
      send_word(40'hFF_FFFF_FF01, 1'b0);
      send_word(POS_MAX, 1'b1);
      // Lowest usable rate with a huge interval.
      set_rate(32'd8000);
      send_word('0, 1'b0);
      send_word(40'h7F_FFFF_FFFF, 1'b1);
   endtask

   task automatic test_random_runs();
      int phase;
      int target;
      logic [CSR_DATA_W-1:0] value;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: value = $urandom_range(8000, 192000);
            1: value = 32'd8000;
            2: value = 32'd192000;
            default: value = ($urandom() & 32'hFFFC_0000) | $urandom_range(8000, 192000);
         endcase
         set_rate(value);
         target = live_words + 25;
         while (live_words < target) send_random_run();
      end
   endtask

   task automatic test_without_idling();
      int target;
      set_rate($urandom_range(8000, 192000));
      sender_idles = 1'b0;
      receiver_stalls <= 1'b0;
      target = live_words + 35;
      while (live_words < target) send_random_run();
      sender_idles = 1'b1;
      receiver_stalls <= 1'b1;
   endtask

   // The receiver holds off while alternating intervals make a marker on every word from the third on.
   task automatic test_output_backpressure();
      longint a, b, p;
      int idx;
      drain_results();
      sender_idles = 1'b0;
      hold_requests <= hold_requests + 1;
      a = $urandom_range(2560, 1000000);
      b = a + $urandom_range(256, 500000);
      p = rand_below(longint'(1) << 36);
      for (idx = 0; idx < 20; idx++) begin
         p = p + ((idx % 2 == 0) ? a : b);
         send_word(p[POS_W-1:0], idx == 19);
      end
      sender_idles = 1'b1;
   endtask

   // Receiver readiness, with a counted hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_OFF_CYCLES;
         rsp_ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (receiver_stalls) begin
         rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Each accepted result word is checked against the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            failures++;
            $display("%0t: unexpected result word: kind %0d position %0d beats %0d tempo %h end %0b",
                     $time, rsp_data.kind, rsp_data.marker_position, rsp_data.beat_count,
                     rsp_data.tempo_q16, rsp_data.end_of_run);
         end else begin
            oldest_word = expected_words.pop_front();
            if (rsp_data.kind !== oldest_word.kind
                || rsp_data.marker_position !== oldest_word.marker_position
                || rsp_data.beat_count !== oldest_word.beat_count
                || rsp_data.tempo_q16 !== oldest_word.tempo_q16
                || rsp_data.end_of_run !== oldest_word.end_of_run) begin
               failures++;
               $display("%0t: expected kind %0d position %0d beats %0d tempo %h end %0b",
                        $time, oldest_word.kind, oldest_word.marker_position,
                        oldest_word.beat_count, oldest_word.tempo_q16, oldest_word.end_of_run);
               $display("%0t:      got kind %0d position %0d beats %0d tempo %h end %0b",
                        $time, rsp_data.kind, rsp_data.marker_position, rsp_data.beat_count,
                        rsp_data.tempo_q16, rsp_data.end_of_run);
            end
         end
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_access();
      test_single_and_steady_runs();
      test_interval_changes();
      test_broken_runs();
      test_rate_extremes();
      test_random_runs();
      test_without_idling();
      test_output_backpressure();
      drain_results();
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
